@@ src/lru_replacement_tracker_macros.svh @@
// Assertion macros shared by the LRU replacement tracker RTL.
`ifndef LRU_REPLACEMENT_TRACKER_MACROS_SVH
`define LRU_REPLACEMENT_TRACKER_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define LRT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define LRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lrt_pkg.sv @@
// Shared constants and types for the LRU replacement tracker.
`default_nettype none
package lrt_pkg;

   // Default sizing
   localparam int DEF_CAPACITY = 16;
   localparam int DEF_KEY_BITS = 32;

   // Fixed field widths on the ports
   localparam int PAGE_KEY_BITS    = 32;
   localparam int ENTRY_COUNT_BITS = 5;
   localparam int REQ_TYPE_BITS    = 2;
   localparam int STATUS_BITS      = 2;
   localparam int REQ_TDATA_BITS   = 32;
   localparam int RSP_TDATA_BITS   = 40;

   typedef logic [REQ_TYPE_BITS-1:0] req_code_type;
   typedef logic [STATUS_BITS-1:0]   status_code_type;

   // Request kinds
   localparam req_code_type REQ_TOUCH = 2'd0;
   localparam req_code_type REQ_EVICT = 2'd1;
   localparam req_code_type REQ_ERASE = 2'd2;

   // Result status codes
   localparam status_code_type ST_DONE = 2'd0;
   localparam status_code_type ST_MISS = 2'd1;
   localparam status_code_type ST_FULL = 2'd2;

   // Per-cell update command
   typedef struct packed {
      logic remove;   // close the gap: cells at or above the removed slot pull from above
      logic load;     // this cell takes the request key
   } lrt_cell_ctrl_type;

endpackage
`default_nettype wire

@@ src/lrt_cell.sv @@
// One slot of the recency chain: holds a key and its valid mark.
`default_nettype none
module lrt_cell #(
   parameter int KEY_BITS = lrt_pkg::DEF_KEY_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lrt_pkg::lrt_cell_ctrl_type ctrl,
   input  wire logic [KEY_BITS-1:0]        req_key,
   input  wire logic [KEY_BITS-1:0]        up_key,
   input  wire logic                       up_valid,
   input  wire logic                       seen_in,
   output logic                            seen_out,
   output logic                            match,
   output logic [KEY_BITS-1:0]             key_out,
   output logic                            valid_out
);
   import lrt_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                valid_ff, valid_in;
   logic                shift;

   // Compare the held key against the request key
   assign match    = valid_ff && (key_ff == req_key);
   // Pass on whether the removed slot lies at or below this cell
   assign seen_out = seen_in | match;
   assign shift    = ctrl.remove & seen_out;

   // Load wins over shift, shift pulls the neighbor's slot down
   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctrl.load) begin
         key_in   = req_key;
         valid_in = 1'b1;
      end else if (shift) begin
         key_in   = up_key;
         valid_in = up_valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key_out   = key_ff;
   assign valid_out = valid_ff;

endmodule
`default_nettype wire

@@ src/lru_replacement_tracker.sv @@
// Top level of the LRU replacement tracker: cell chain, request decode, result register.
//
// Usage:
//  Request beats come in on req_*: req_tuser carries the kind (touch, evict,
//  erase) and req_tdata the page key. Each accepted request yields exactly one
//  result beat on rsp_*: rsp_tuser carries the status, rsp_tdata the victim key
//  and the count of keys held after the request.
//  The result is registered at the edge that accepts the request and shows on
//  rsp_tvalid from the next cycle. Throughput is one request per cycle while
//  the receiver takes results; every slot of the cell chain compares its key in
//  parallel and shifts toward slot 0 (least recent) in that same cycle.
//  Reset clears all valid marks and the count; keys are not cleared and no
//  clearing pass is needed, so requests are taken from the first cycle after
//  reset.
//  When the receiver stalls, the result holds in the output register and
//  req_tready drops until it is taken; a taken result frees room for a new
//  request in that same cycle.
`default_nettype none
module lru_replacement_tracker #(
   parameter int CAPACITY = lrt_pkg::DEF_CAPACITY,
   parameter int KEY_BITS = lrt_pkg::DEF_KEY_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lrt_pkg::REQ_TDATA_BITS-1:0]  req_tdata,  // [31:0] page_key
   input  wire logic [lrt_pkg::REQ_TYPE_BITS-1:0]   req_tuser,  // [1:0] req_type
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lrt_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,  // [31:0] victim_key,
                                                                // [36:32] entry_count
   output logic [lrt_pkg::STATUS_BITS-1:0]          rsp_tuser   // [1:0] status
);
   import lrt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   // Chain wiring
   logic [KEY_BITS-1:0]  key_vec [CAPACITY];
   logic [CAPACITY-1:0]  valid_vec;
   logic [CAPACITY-1:0]  match_vec;
   logic [CAPACITY:0]    seen_vec;
   lrt_cell_ctrl_type    ctrl_vec [CAPACITY];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_code_type      status_ff, status_in;
   logic [PAGE_KEY_BITS-1:0]    victim_ff, victim_in;
   logic [ENTRY_COUNT_BITS-1:0] entry_count_ff, entry_count_in;

   logic                 req_fire;
   req_code_type         req_type;
   logic [KEY_BITS-1:0]  req_key;
   logic                 hit, full, empty;
   logic                 remove_en, load_en, evict_en;
   logic [CNT_W-1:0]     load_pos_full;
   logic [IDX_W-1:0]     load_pos;

   assign req_type   = req_tuser;
   assign req_key    = KEY_BITS'(req_tdata[PAGE_KEY_BITS-1:0]);
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;

   assign hit   = |match_vec;
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // Decode the request into chain commands, status and new count
   always_comb begin
      remove_en = 1'b0;
      load_en   = 1'b0;
      evict_en  = 1'b0;
      status_in = ST_MISS;
      victim_in = '0;
      count_in  = count_ff;
      case (req_type)
         REQ_TOUCH: begin
            if (hit) begin
               remove_en = 1'b1;
               load_en   = 1'b1;
               status_in = ST_DONE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               load_en   = 1'b1;
               status_in = ST_DONE;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         REQ_EVICT: begin
            if (!empty) begin
               remove_en = 1'b1;
               evict_en  = 1'b1;
               status_in = ST_DONE;
               victim_in = PAGE_KEY_BITS'(key_vec[0]);
               count_in  = count_ff - CNT_W'(1);
            end
         end
         REQ_ERASE: begin
            if (hit) begin
               remove_en = 1'b1;
               status_in = ST_DONE;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
      remove_en = remove_en & req_fire;
      load_en   = load_en & req_fire;
   end

   // The touched key lands at the most-recent end after any gap closes
   assign load_pos_full = count_ff - CNT_W'(hit);
   assign load_pos      = load_pos_full[IDX_W-1:0];

   // Evict removes slot 0, so every cell shifts
   assign seen_vec[0] = evict_en;

   // Build the chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0] up_key;
      logic                up_valid;

      if (i == CAPACITY - 1) begin : g_top
         assign up_key   = '0;
         assign up_valid = 1'b0;
      end else begin : g_mid
         assign up_key   = key_vec[i+1];
         assign up_valid = valid_vec[i+1];
      end

      assign ctrl_vec[i].remove = remove_en;
      assign ctrl_vec[i].load   = load_en && (load_pos == IDX_W'(i));

      lrt_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl_vec[i]),
         .req_key   (req_key),
         .up_key    (up_key),
         .up_valid  (up_valid),
         .seen_in   (seen_vec[i]),
         .seen_out  (seen_vec[i+1]),
         .match     (match_vec[i]),
         .key_out   (key_vec[i]),
         .valid_out (valid_vec[i])
      );
   end

   assign entry_count_in = ENTRY_COUNT_BITS'(count_in);
   assign rsp_valid_in   = req_fire | (rsp_valid_ff & ~rsp_tready);

   // Advance count and hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff      <= status_in;
         victim_ff      <= victim_in;
         entry_count_ff <= entry_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({entry_count_ff, victim_ff});

`include "lru_replacement_tracker_macros.svh"

   `LRT_ASSERT_SAME(a_valid_matches_count, clock, reset, 1'b1, CNT_W'($countones(valid_vec)) == count_ff, "valid marks disagree with count")
   `LRT_ASSERT_SAME(a_single_match, clock, reset, 1'b1, $onehot0(match_vec), "key held in more than one slot")
   `LRT_ASSERT_SAME(a_full_only_at_capacity, clock, reset, rsp_valid_ff && (status_ff == ST_FULL), count_ff == CNT_W'(CAPACITY), "full reported below capacity")
   `LRT_ASSERT_NEXT(a_evict_drops_one, clock, reset, req_fire && (req_type == REQ_EVICT) && !empty, count_ff == $past(count_ff) - CNT_W'(1), "evict did not drop one key")

endmodule
`default_nettype wire
